FILE: src/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, sizes and helpers for the counter machine step block.
// ----------------------------------------------------------------------------
package cms_pkg;

  // store sizes
  localparam int PROG_DEPTH  = 256;
  localparam int NUM_REGS    = 16;
  localparam int VALUE_WIDTH = 32;

  // derived widths
  localparam int PROG_AW = $clog2(PROG_DEPTH);
  localparam int REG_AW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // fixed field widths
  localparam int PC_W    = 9;
  localparam int LEN_W   = 9;
  localparam int IDX_W   = 8;
  localparam int ARG_W   = 8;
  localparam int CODE_W  = 2;
  localparam int WORD_W  = CODE_W + ARG_W;
  localparam int OUT_W   = 32;

  localparam logic [PC_W-1:0] PC_MAX = '1;

  // config register byte address bit and index
  localparam logic REG_PROGRAM_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_WRITE = 2'd1,
    OP_STEP  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    INS_INC   = 2'd0,
    INS_DEC   = 2'd1,
    INS_PRINT = 2'd2,
    INS_JMP   = 2'd3
  } instr_t;

  // register number reduced to the file size (8-bit input, a small table)
  function automatic logic [REG_AW-1:0] reg_sel(input logic [IDX_W-1:0] i);
    logic [15:0] r;
    r = 16'(i) % 16'(NUM_REGS);
    return r[REG_AW-1:0];
  endfunction

  // pc at or past the effective program length, or pinned at the top
  function automatic logic halted_of(input logic [PC_W-1:0] pc,
                                     input logic [LEN_W-1:0] len);
    logic [15:0] eff;
    eff = (16'(len) > 16'(PROG_DEPTH)) ? 16'(PROG_DEPTH) : 16'(len);
    return (16'(pc) >= eff) || (pc == PC_MAX);
  endfunction

  // saturating pc advance
  function automatic logic [PC_W-1:0] pc_add(input logic [PC_W-1:0] pc,
                                             input logic [ARG_W-1:0] amt);
    logic [PC_W:0] sum;
    sum = {1'b0, pc} + (PC_W+1)'(amt);
    return sum[PC_W] ? PC_MAX : sum[PC_W-1:0];
  endfunction

  // register value to the 32-bit result fields
  function automatic logic [OUT_W-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_W-1:0];
  endfunction

  // 32-bit written value to the register width
  function automatic logic [VALUE_WIDTH-1:0] from_in(input logic [OUT_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[VALUE_WIDTH-1:0];
  endfunction

endpackage

FILE: src/cms_ram.sv
// ----------------------------------------------------------------------------
// cms_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/counter_machine_step.sv
// ----------------------------------------------------------------------------
// counter_machine_step
// Counter machine interpreter: loads program words, writes and reads
// registers and executes one instruction per step word.
//
//   channel | dir | handshake           | contents
//   --------+-----+---------------------+-----------------------------------
//   in      | in  | in_valid / in_stall  | opcode index instr_code operand value
//   out     | out | out_valid / out_stall| print_valid print_value halted
//           |     |                     |   pc_now read_value
//   cfg     | in  | APB psel/penable    | program_length at address 0
//
// A load, write, read or halted step goes from accept through S_FINISH to the result.
// A running step passes through program word read, register read, then
// execute and write back; the two registered RAM reads set this order.
// Reset clears pc, program length and the register valid bits, so every
// register reads zero until written; no clearing pass is needed.
// A stalled result holds the block in its last state; write back and pc
// update happen only when the result word moves to the output register.
// ----------------------------------------------------------------------------
module counter_machine_step (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  index,
  input  logic [1:0]  instr_code,
  input  logic [7:0]  operand,
  input  logic [31:0] value,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        print_valid,
  output logic [31:0] print_value,
  output logic        halted,
  output logic [8:0]  pc_now,
  output logic [31:0] read_value,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_FINISH
  } state_t;

  state_t                         state;
  logic [cms_pkg::PC_W-1:0]       pc;
  logic [cms_pkg::LEN_W-1:0]      program_length;
  logic [cms_pkg::NUM_REGS-1:0]   reg_valid;
  logic                           reg_ok;
  cms_pkg::op_t                   op_q;

  logic                           accept;
  logic                           out_free;
  logic                           out_load;
  logic                           running;

  // program RAM ports
  logic                           prog_we;
  logic [cms_pkg::PROG_AW-1:0]    prog_waddr;
  logic [cms_pkg::WORD_W-1:0]     prog_wdata;
  logic                           prog_re;
  logic [cms_pkg::PROG_AW-1:0]    prog_raddr;
  logic [cms_pkg::WORD_W-1:0]     prog_q;

  // register RAM ports
  logic                           reg_we;
  logic [cms_pkg::REG_AW-1:0]     reg_waddr;
  logic [cms_pkg::VALUE_WIDTH-1:0] reg_wdata;
  logic                           reg_re;
  logic [cms_pkg::REG_AW-1:0]     reg_raddr;
  logic [cms_pkg::VALUE_WIDTH-1:0] reg_q;

  // execute datapath
  cms_pkg::instr_t                 icode;
  logic [cms_pkg::ARG_W-1:0]       arg;
  logic [cms_pkg::VALUE_WIDTH-1:0] rv;
  logic [cms_pkg::VALUE_WIDTH-1:0] wb_data;
  logic                            wb_en;
  logic [cms_pkg::PC_W-1:0]        pc_next;
  logic                            pv_next;
  logic [15:0]                     idx_ext;
  logic [15:0]                     pc_ext;
  logic                            cfg_wr;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = ((state == S_EXEC) || (state == S_FINISH)) && out_free;
  assign running  = !cms_pkg::halted_of(pc, program_length);

  assign idx_ext = 16'(index);
  assign pc_ext  = 16'(pc);

  // config register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == cms_pkg::REG_PROGRAM_LENGTH);
  assign prdata = (paddr[2] == cms_pkg::REG_PROGRAM_LENGTH) ?
                  32'(program_length) : 32'd0;

  // program store: load on accept, fetch at pc on every accepted step
  assign prog_we    = accept && (cms_pkg::op_t'(opcode) == cms_pkg::OP_LOAD) &&
                      (idx_ext < 16'(cms_pkg::PROG_DEPTH));
  assign prog_waddr = idx_ext[cms_pkg::PROG_AW-1:0];
  assign prog_wdata = {instr_code, operand};
  assign prog_re    = accept && (cms_pkg::op_t'(opcode) == cms_pkg::OP_STEP);
  assign prog_raddr = pc_ext[cms_pkg::PROG_AW-1:0];

  // fetched word fields and register operand
  assign icode = cms_pkg::instr_t'(prog_q[cms_pkg::WORD_W-1:cms_pkg::ARG_W]);
  assign arg   = prog_q[cms_pkg::ARG_W-1:0];
  assign rv    = reg_ok ? reg_q : '0;

  // instruction execute
  always_comb begin
    wb_en   = 1'b0;
    wb_data = rv;
    pv_next = 1'b0;
    pc_next = pc;
    case (icode)
      cms_pkg::INS_INC: begin
        wb_en   = 1'b1;
        wb_data = rv + 1'b1;
        pc_next = cms_pkg::pc_add(pc, 8'd1);
      end
      cms_pkg::INS_DEC: begin
        if (rv == '0) begin
          pc_next = cms_pkg::pc_add(pc, 8'd2);
        end else begin
          wb_en   = 1'b1;
          wb_data = rv - 1'b1;
          pc_next = cms_pkg::pc_add(pc, 8'd1);
        end
      end
      cms_pkg::INS_PRINT: begin
        pv_next = 1'b1;
        pc_next = cms_pkg::pc_add(pc, 8'd1);
      end
      cms_pkg::INS_JMP: begin
        pc_next = cms_pkg::pc_add(pc, arg);
      end
      default: begin
        pc_next = pc;
      end
    endcase
  end

  // register file ports: host write on accept, write back at commit
  always_comb begin
    reg_we    = 1'b0;
    reg_waddr = cms_pkg::reg_sel(index);
    reg_wdata = cms_pkg::from_in(value);
    reg_re    = 1'b0;
    reg_raddr = cms_pkg::reg_sel(index);
    if (accept && (cms_pkg::op_t'(opcode) == cms_pkg::OP_WRITE)) begin
      reg_we = 1'b1;
    end
    if (accept && (cms_pkg::op_t'(opcode) == cms_pkg::OP_READ)) begin
      reg_re = 1'b1;
    end
    if (state == S_FETCH) begin
      reg_re    = 1'b1;
      reg_raddr = cms_pkg::reg_sel(arg);
    end
    if ((state == S_EXEC) && out_free && wb_en) begin
      reg_we    = 1'b1;
      reg_waddr = cms_pkg::reg_sel(arg);
      reg_wdata = wb_data;
    end
  end

  cms_ram #(
    .WIDTH (cms_pkg::WORD_W),
    .DEPTH (cms_pkg::PROG_DEPTH)
  ) u_prog_ram (
    .clk     (clk),
    .wr_en   (prog_we),
    .wr_addr (prog_waddr),
    .wr_data (prog_wdata),
    .rd_en   (prog_re),
    .rd_addr (prog_raddr),
    .rd_data (prog_q)
  );

  cms_ram #(
    .WIDTH (cms_pkg::VALUE_WIDTH),
    .DEPTH (cms_pkg::NUM_REGS)
  ) u_reg_ram (
    .clk     (clk),
    .wr_en   (reg_we),
    .wr_addr (reg_waddr),
    .wr_data (reg_wdata),
    .rd_en   (reg_re),
    .rd_addr (reg_raddr),
    .rd_data (reg_q)
  );

  // sequencer, machine state and output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pc             <= '0;
      program_length <= '0;
      reg_valid      <= '0;
      reg_ok         <= 1'b0;
      op_q           <= cms_pkg::OP_LOAD;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        program_length <= pwdata[cms_pkg::LEN_W-1:0];
      end
      // output word: load a new one or drop the one taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (reg_we) begin
        reg_valid[reg_waddr] <= 1'b1;
      end
      if (reg_re) begin
        reg_ok <= reg_valid[reg_raddr];
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q <= cms_pkg::op_t'(opcode);
            if ((cms_pkg::op_t'(opcode) == cms_pkg::OP_STEP) && running) begin
              state <= S_FETCH;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FETCH: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            pc          <= pc_next;
            print_valid <= pv_next;
            print_value <= pv_next ? cms_pkg::to_out(rv) : '0;
            halted      <= cms_pkg::halted_of(pc_next, program_length);
            pc_now      <= pc_next;
            read_value  <= '0;
            state       <= S_IDLE;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            print_valid <= 1'b0;
            print_value <= '0;
            halted      <= !running;
            pc_now      <= pc;
            read_value  <= (op_q == cms_pkg::OP_READ) ? cms_pkg::to_out(rv) : '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
